FILE: rtl/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants of the 1-Wire temperature reader
// Phase codes, result kind codes, slot byte values and the state and
// result records passed between the sequencer step and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package owtr_pkg;

   // scratchpad size, the read slot count derived from it, and the command and word slot counts
   localparam int SCRATCHPAD_BYTES = 9;
   localparam int SLOT_W           = 7;
   localparam logic [SLOT_W-1:0] READ_SLOTS = SLOT_W'(SCRATCHPAD_BYTES * 8);
   localparam logic [SLOT_W-1:0] CMD_SLOTS  = SLOT_W'(16);
   localparam logic [SLOT_W-1:0] WORD_SLOTS = SLOT_W'(16);

   // sequencer phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_RST1 = 3'd1;
   localparam logic [2:0] PH_WR1  = 3'd2;
   localparam logic [2:0] PH_POLL = 3'd3;
   localparam logic [2:0] PH_RST2 = 3'd4;
   localparam logic [2:0] PH_WR2  = 3'd5;
   localparam logic [2:0] PH_READ = 3'd6;

   // request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_ECHO  = 1'b1;

   // result kinds
   localparam logic [1:0] RK_TX    = 2'd0;
   localparam logic [1:0] RK_TEMP  = 2'd1;
   localparam logic [1:0] RK_ABORT = 2'd2;

   // line bytes and 1-Wire commands (skip ROM in the low byte)
   localparam logic [7:0]  RESET_BYTE   = 8'hF0;
   localparam logic [7:0]  PRESENCE_MAX = 8'hE0;
   localparam logic [7:0]  SLOT_ONE     = 8'hFF;
   localparam logic [7:0]  SLOT_ZERO    = 8'h00;
   localparam logic [15:0] CMD_CONVERT  = 16'h44CC;
   localparam logic [15:0] CMD_READPAD  = 16'hBECC;

   typedef struct packed {
      logic [2:0]        phase;
      logic [SLOT_W-1:0] slot_count;
      logic [15:0]       command_bits;
      logic [15:0]       low_word;
   } state_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         tx_byte;
      logic               slow_baud;
      logic signed [11:0] temperature;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/owtr_step.sv
// ----------------------------------------------------------------------------
// owtr_step: one sequencer step of the 1-Wire temperature reader
// Given the current state and one request beat, computes the next state
// and the result beat (if any) in a single pass of logic.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_step
   import owtr_pkg::*;
(
   input  wire state_type  cur,
   input  wire logic       kind,
   input  wire logic [7:0] echo_byte,
   output state_type       nxt,
   output rsp_type         res,
   output logic            has_res
);

   logic [SLOT_W-1:0] slot_inc;

   always_comb begin
      nxt      = cur;
      res      = '0;
      has_res  = 1'b0;
      slot_inc = cur.slot_count + SLOT_W'(1);

      if (kind == KIND_START) begin
         // restart the cycle with the first reset pulse
         nxt            = '0;
         nxt.phase      = PH_RST1;
         res.tx_byte    = RESET_BYTE;
         res.slow_baud  = 1'b1;
         has_res        = 1'b1;
      end else begin
         unique case (cur.phase) inside
            PH_RST1, PH_RST2: begin
               // check presence, then start the command write slots, else abort
               has_res = 1'b1;
               if (echo_byte <= PRESENCE_MAX) begin
                  nxt.command_bits = (cur.phase == PH_RST1) ? CMD_CONVERT : CMD_READPAD;
                  nxt.slot_count   = '0;
                  nxt.phase        = (cur.phase == PH_RST1) ? PH_WR1 : PH_WR2;
                  res.tx_byte      = nxt.command_bits[0] ? SLOT_ONE : SLOT_ZERO;
               end else begin
                  nxt.phase       = PH_IDLE;
                  res.result_kind = RK_ABORT;
               end
            end
            PH_WR1, PH_WR2: begin
               // advance through the command bits, then poll (first command) or open the read slots
               has_res = 1'b1;
               if (slot_inc >= CMD_SLOTS) begin
                  nxt.slot_count = '0;
                  if (cur.phase == PH_WR1) begin
                     nxt.phase = PH_POLL;
                  end else begin
                     nxt.phase    = PH_READ;
                     nxt.low_word = '0;
                  end
                  res.tx_byte = SLOT_ONE;
               end else begin
                  nxt.slot_count = slot_inc;
                  res.tx_byte    = cur.command_bits[slot_inc[3:0]] ? SLOT_ONE : SLOT_ZERO;
               end
            end
            PH_POLL: begin
               // poll until the conversion reports done
               has_res = 1'b1;
               if (echo_byte == SLOT_ONE) begin
                  nxt.phase     = PH_RST2;
                  res.tx_byte   = RESET_BYTE;
                  res.slow_baud = 1'b1;
               end else begin
                  res.tx_byte = SLOT_ONE;
               end
            end
            PH_READ: begin
               // collect the low word, drop the remaining scratchpad bits
               has_res = 1'b1;
               if (cur.slot_count < WORD_SLOTS && echo_byte == SLOT_ONE) begin
                  nxt.low_word[cur.slot_count[3:0]] = 1'b1;
               end
               if (slot_inc >= READ_SLOTS) begin
                  nxt.phase       = PH_IDLE;
                  nxt.slot_count  = '0;
                  res.result_kind = RK_TEMP;
                  res.temperature = $signed(nxt.low_word[15:4]);
               end else begin
                  nxt.slot_count = slot_inc;
                  res.tx_byte    = SLOT_ONE;
               end
            end
            default: begin
               // echo while idle: ignore
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/owtr_skid.sv
// ----------------------------------------------------------------------------
// owtr_skid: result register with one skid entry
// Holds the result beat for the receiver and parks one more beat while the
// receiver stalls, so the sequencer keeps taking beats.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_skid
   import owtr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_stall
);

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    out_free;
   logic    push;

   assign in_stall  = skid_valid_ff;
   assign out_free  = !out_valid_ff || !out_stall;
   assign push      = in_valid && !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // control: output and skid occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload: advance from skid or input, park on stall
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (push) begin
            out_data_ff <= in_data;
         end
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/onewire_uart_temperature_reader.sv
// ----------------------------------------------------------------------------
// onewire_uart_temperature_reader: 1-Wire temperature read over a UART
// A result beat reaches rsp_ through the registered result stage.
// Throughput: one request beat per cycle; req_stall rises only when the
// result register and its skid entry are both held by rsp_stall.
// Reset: the sequencer returns to idle and the result stage empties.
// Sequences reset pulses, command write slots, conversion polling and the
// scratchpad read, and reports the temperature in whole degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_uart_temperature_reader
   import owtr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_echo_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_result_kind,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_slow_baud,
   output logic signed [11:0]      rsp_temperature
);

   state_type state_ff;
   state_type state_in;
   rsp_type   step_res;
   rsp_type   out_data;
   logic      step_has;
   logic      accept;

   assign accept = req_valid && !req_stall;

   owtr_step u_step (
      .cur       (state_ff),
      .kind      (req_kind),
      .echo_byte (req_echo_byte),
      .nxt       (state_in),
      .res       (step_res),
      .has_res   (step_has)
   );

   // hold sequencer state, advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   owtr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && step_has),
      .in_data   (step_res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_result_kind = out_data.result_kind;
   assign rsp_tx_byte     = out_data.tx_byte;
   assign rsp_slow_baud   = out_data.slow_baud;
   assign rsp_temperature = out_data.temperature;

endmodule

`default_nettype wire

FILE: tb/sv/owtr_checker.sv
// ----------------------------------------------------------------------------
// owtr_checker: result scoreboard for the 1-Wire temperature reader
// Watches the request and result channels. Every accepted request beat is
// run through a cycle-free model of the read sequencer: reset pulses,
// command write slots, conversion polling and the scratchpad read. The
// result beat it yields is queued. Each accepted result beat is compared
// field by field with the oldest queued one. Mismatches and result beats
// that arrive with nothing queued are counted for the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_checker
   import owtr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_echo_byte,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic [1:0]         rsp_result_kind,
   input  wire logic [7:0]         rsp_tx_byte,
   input  wire logic               rsp_slow_baud,
   input  wire logic signed [11:0] rsp_temperature,
   output int                      mismatch_count,
   output int                      expected_count
);

   localparam int REPORT_LIMIT = 10;

   state_type seq;
   rsp_type   line_beats[$];

   // Advance the sequencer model by one request; return 1 when it yields a beat.
   function automatic bit step_sequencer(input logic kind, input logic [7:0] echo,
                                         output rsp_type beat);
      logic [2:0] cur;
      cur  = seq.phase;
      beat = '0;
      beat.result_kind = RK_TX;
      // a start always restarts from the first reset pulse
      if (kind == KIND_START) begin
         seq.phase        = PH_RST1;
         seq.slot_count   = '0;
         seq.command_bits = '0;
         seq.low_word     = '0;
         beat.tx_byte     = RESET_BYTE;
         beat.slow_baud   = 1'b1;
         return 1'b1;
      end
      case (cur)
         PH_RST1, PH_RST2: begin
            if (echo <= PRESENCE_MAX) begin
               seq.command_bits = (cur == PH_RST1) ? CMD_CONVERT : CMD_READPAD;
               seq.slot_count   = '0;
               seq.phase        = (cur == PH_RST1) ? PH_WR1 : PH_WR2;
               beat.tx_byte     = seq.command_bits[0] ? SLOT_ONE : SLOT_ZERO;
            end else begin
               seq.phase        = PH_IDLE;
               beat.result_kind = RK_ABORT;
            end
            return 1'b1;
         end
         PH_WR1, PH_WR2: begin
            seq.slot_count = seq.slot_count + 1'b1;
            if (seq.slot_count >= CMD_SLOTS) begin
               seq.slot_count = '0;
               if (cur == PH_WR1) begin
                  seq.phase = PH_POLL;
               end else begin
                  seq.phase    = PH_READ;
                  seq.low_word = '0;
               end
               beat.tx_byte = SLOT_ONE;
            end else begin
               beat.tx_byte = seq.command_bits[seq.slot_count[3:0]] ? SLOT_ONE : SLOT_ZERO;
            end
            return 1'b1;
         end
         PH_POLL: begin
            // conversion done once a read slot comes back as one
            if (echo == SLOT_ONE) begin
               seq.phase      = PH_RST2;
               beat.tx_byte   = RESET_BYTE;
               beat.slow_baud = 1'b1;
            end else begin
               beat.tx_byte   = SLOT_ONE;
            end
            return 1'b1;
         end
         PH_READ: begin
            // collect the first two scratchpad bytes, drop the rest
            if (seq.slot_count < WORD_SLOTS && echo == SLOT_ONE) begin
               seq.low_word[seq.slot_count[3:0]] = 1'b1;
            end
            seq.slot_count = seq.slot_count + 1'b1;
            if (seq.slot_count >= READ_SLOTS) begin
               seq.phase        = PH_IDLE;
               seq.slot_count   = '0;
               beat.result_kind = RK_TEMP;
               beat.temperature = seq.low_word[15:4];
            end else begin
               beat.tx_byte     = SLOT_ONE;
            end
            return 1'b1;
         end
         default: begin
            seq.phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   // Count a bad result beat; print only the first few.
   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: rsp %s: expected kind=%0d tx=%02h slow=%0d temp=%0d",
                  $time, what, want.result_kind, want.tx_byte, want.slow_baud,
                  want.temperature);
         $display("%0t: rsp %s: got      kind=%0d tx=%02h slow=%0d temp=%0d",
                  $time, what, got.result_kind, got.tx_byte, got.slow_baud,
                  got.temperature);
      end
   endtask

   // Check result beats against the queue, then queue what new requests yield.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      rsp_type next_beat;
      if (reset) begin
         seq = '0;
         line_beats.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.result_kind = rsp_result_kind;
            got.tx_byte     = rsp_tx_byte;
            got.slow_baud   = rsp_slow_baud;
            got.temperature = rsp_temperature;
            if (line_beats.size() == 0) begin
               note_mismatch("beat with none pending", '0, got);
            end else begin
               want = line_beats.pop_front();
               if (got.result_kind != want.result_kind || got.tx_byte != want.tx_byte ||
                   got.slow_baud != want.slow_baud || got.temperature != want.temperature) begin
                  note_mismatch("field mismatch", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (step_sequencer(req_kind, req_echo_byte, next_beat)) begin
               line_beats.push_back(next_beat);
            end
         end
      end
      expected_count = line_beats.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 1-Wire temperature reader
// Drives short directed requests (presence extremes, abort, echoes while
// idle, restarts while busy) and then mostly well-formed read cycles with
// random echo content, mixed with broken cycles and stray echoes. Both
// channels idle at random, with a long result hold-off and a full drain
// pause once each. The checker beside the block scores every result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import owtr_pkg::*;

   localparam int ITEM_TARGET  = 1650;
   localparam int QUIET_LIMIT  = 2000;
   localparam int LONG_HOLD    = 80;
   localparam int DRAIN_CYCLES = 8;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_kind;
   logic [7:0]         req_echo_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_result_kind;
   logic [7:0]         rsp_tx_byte;
   logic               rsp_slow_baud;
   logic signed [11:0] rsp_temperature;
   int                 mismatch_count;
   int                 expected_count;

   int items_sent;
   int quiet_cycles;
   bit burst_mode;
   bit long_hold_pending;
   bit line_idle;

   onewire_uart_temperature_reader dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_echo_byte   (req_echo_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_slow_baud   (rsp_slow_baud),
      .rsp_temperature (rsp_temperature)
   );

   owtr_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_echo_byte   (req_echo_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_slow_baud   (rsp_slow_baud),
      .rsp_temperature (rsp_temperature),
      .mismatch_count  (mismatch_count),
      .expected_count  (expected_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offer one request beat after a random gap and hold it until accepted.
   task automatic drive_beat(input logic kind, input logic [7:0] echo, input bit counted);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_echo_byte <= echo;
      do @(posedge clock); while (req_stall);
      if (counted) items_sent++;
   endtask

   task automatic send_start();
      drive_beat(KIND_START, 8'($urandom_range(0, 255)), 1'b1);
      line_idle = 1'b0;
   endtask

   function automatic logic [7:0] presence_echo(input bit present);
      if (present) return 8'($urandom_range(0, PRESENCE_MAX));
      return 8'($urandom_range(PRESENCE_MAX + 1, 255));
   endfunction

   // Run one full read cycle; the first two scratchpad bytes carry the word.
   task automatic run_read_cycle(input int word_mode, input bit may_abort);
      logic [15:0] word;
      int          polls;
      case (word_mode)
         0:       word = 16'h7FFF;
         1:       word = 16'h8000;
         2:       word = 16'hFFFF;
         3:       word = 16'h0000;
         4:       word = 16'h000F;
         default: word = 16'($urandom);
      endcase
      send_start();
      if (may_abort && $urandom_range(0, 9) == 0) begin
         drive_beat(KIND_ECHO, presence_echo(1'b0), 1'b1);
         line_idle = 1'b1;
         return;
      end
      drive_beat(KIND_ECHO, presence_echo(1'b1), 1'b1);
      // write slot echoes are not examined
      repeat (16) drive_beat(KIND_ECHO, 8'($urandom_range(0, 255)), 1'b1);
      polls = $urandom_range(0, 4);
      repeat (polls) drive_beat(KIND_ECHO, 8'($urandom_range(0, SLOT_ONE - 1)), 1'b1);
      drive_beat(KIND_ECHO, SLOT_ONE, 1'b1);
      if (may_abort && $urandom_range(0, 9) == 0) begin
         drive_beat(KIND_ECHO, presence_echo(1'b0), 1'b1);
         line_idle = 1'b1;
         return;
      end
      drive_beat(KIND_ECHO, presence_echo(1'b1), 1'b1);
      repeat (16) drive_beat(KIND_ECHO, 8'($urandom_range(0, 255)), 1'b1);
      for (int i = 0; i < READ_SLOTS; i++) begin
         if (i < 16 && word[i]) begin
            drive_beat(KIND_ECHO, SLOT_ONE, 1'b1);
         end else begin
            drive_beat(KIND_ECHO, 8'($urandom_range(0, (i < 16) ? 254 : 255)), 1'b1);
         end
      end
      line_idle = 1'b1;
   endtask

   // Receiver: random stall per beat, plus one long hold-off on request.
   initial begin
      int wait_len;
      do @(negedge clock); while (reset);
      forever begin
         if (long_hold_pending) begin
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            long_hold_pending = 1'b0;
         end
         wait_len = burst_mode ? 0 : $urandom_range(0, 3);
         repeat (wait_len) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("onewire_uart_temperature_reader test failed");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int cycle_index;
      int choice;
      int noise_len;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_START;
      req_echo_byte     = 8'h00;
      rsp_stall         = 1'b0;
      items_sent        = 0;
      burst_mode        = 1'b0;
      long_hold_pending = 1'b0;
      line_idle         = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: idle echoes, presence limits, restarts while busy
      drive_beat(KIND_ECHO, 8'h00, 1'b0);
      send_start();
      drive_beat(KIND_ECHO, PRESENCE_MAX + 8'd1, 1'b1);
      drive_beat(KIND_ECHO, SLOT_ONE, 1'b0);
      send_start();
      drive_beat(KIND_ECHO, PRESENCE_MAX, 1'b1);
      drive_beat(KIND_ECHO, SLOT_ONE, 1'b1);
      drive_beat(KIND_ECHO, SLOT_ZERO, 1'b1);
      send_start();
      drive_beat(KIND_ECHO, 8'h00, 1'b1);
      drive_beat(KIND_ECHO, 8'hA5, 1'b1);
      drive_beat(KIND_ECHO, 8'h5A, 1'b1);
      send_start();
      send_start();
      drive_beat(KIND_ECHO, 8'hFF, 1'b1);
      drive_beat(KIND_ECHO, 8'h7E, 1'b0);
      line_idle = 1'b1;

      // random: mostly full read cycles, some broken cycles and noise
      cycle_index = 0;
      while (items_sent < ITEM_TARGET) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         if (cycle_index == 6) long_hold_pending = 1'b1;
         if (cycle_index == 9) begin
            // pause the sender until every result beat has drained
            @(negedge clock);
            req_valid <= 1'b0;
            while (expected_count != 0) @(negedge clock);
         end
         choice = $urandom_range(0, 9);
         if (cycle_index < 5 || choice < 7) begin
            run_read_cycle((cycle_index < 5) ? cycle_index : 5, cycle_index >= 5);
         end else if (choice == 7) begin
            send_start();
            noise_len = $urandom_range(1, 40);
            repeat (noise_len) begin
               drive_beat(($urandom_range(0, 7) == 0) ? KIND_START : KIND_ECHO,
                          8'($urandom_range(0, 255)), 1'b1);
            end
         end else if (line_idle) begin
            noise_len = $urandom_range(1, 3);
            repeat (noise_len) drive_beat(KIND_ECHO, 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            run_read_cycle(5, 1'b1);
         end
         cycle_index++;
      end

      // drain and give the verdict
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_count == 0) begin
         $display("onewire_uart_temperature_reader test passed");
      end else begin
         $display("onewire_uart_temperature_reader test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
